[sv/mkdpt_pkg.sv]
// Shared constants and types for the multi-key debounce and press timer.
package mkdpt_pkg;

    localparam int NUM_KEYS = 4;
    localparam int SETTLE_W = 8;
    localparam int DUR_W    = 16;

    localparam logic [SETTLE_W-1:0] DEBOUNCE_RESET = 8'd50;
    localparam logic [SETTLE_W-1:0] SETTLE_MAX     = {SETTLE_W{1'b1}};
    localparam logic [DUR_W-1:0]    DUR_MAX        = {DUR_W{1'b1}};

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 2 * NUM_KEYS + NUM_KEYS * DUR_W;

    // Per-key result of one tick, as seen after the update.
    typedef struct packed {
        logic             release_evt;
        logic             down;
        logic [DUR_W-1:0] duration;
    } key_stat_t;

endpackage

[sv/multi_key_debounce_press_timer_top.sv]
// Top level: tick stream in, per-tick key result stream out, debounce register.
//
// Each accepted s_tdata beat is one time tick carrying the raw active-low
// levels of four keys; each tick yields exactly one m_tdata beat in the next
// cycle, holding the release-event mask, the debounced down mask and the last
// press length of every key. The block takes one tick per cycle: the per-key
// state registers are updated by one level of logic on acceptance and the
// result lands in a single output register, which frees up in the same cycle
// it is taken, so s_tready stays high as long as m_tready is high. A write on
// the cfg channel sets the debounce wait in ticks (reset 50, 0 behaves as 1)
// and is always taken, as cfg_ready is tied high.
module multi_key_debounce_press_timer_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [mkdpt_pkg::IN_TDATA_W-1:0]       s_tdata,  // [3:0] key_levels
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // [3:0] release_mask, [7:4] down_mask, [23:8] duration_key0,
    // [39:24] duration_key1, [55:40] duration_key2, [71:56] duration_key3
    output logic [mkdpt_pkg::OUT_TDATA_W-1:0]      m_tdata,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [mkdpt_pkg::SETTLE_W-1:0]         cfg_data   // debounce_ticks
);
    import mkdpt_pkg::*;

    logic [SETTLE_W-1:0] debounce_reg;
    logic                out_valid_reg;
    logic [NUM_KEYS-1:0] rel_reg;
    logic [NUM_KEYS-1:0] down_reg;
    logic [DUR_W-1:0]    dur_reg [NUM_KEYS];
    logic                step;
    key_stat_t           stat [NUM_KEYS];

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign step      = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            debounce_reg <= DEBOUNCE_RESET;
        else if (cfg_valid && cfg_ready)
            debounce_reg <= cfg_data;
    end

    genvar k;
    generate
        for (k = 0; k < NUM_KEYS; k++)
        begin : g_key
            mkdpt_key u_key (
                .clk            (clk),
                .rst_n          (rst_n),
                .step           (step),
                .level_high     (s_tdata[k]),
                .debounce_ticks (debounce_reg),
                .stat           (stat[k])
            );
        end
    endgenerate

    // result payload: loaded on every accepted tick
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                rel_reg[i]  <= stat[i].release_evt;
                down_reg[i] <= stat[i].down;
                dur_reg[i]  <= stat[i].duration;
            end
        end
    end

    always_comb
    begin
        m_tdata = '0;
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            m_tdata[i]                             = rel_reg[i];
            m_tdata[NUM_KEYS + i]                  = down_reg[i];
            m_tdata[2*NUM_KEYS + i*DUR_W +: DUR_W] = dur_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    assign m_tvalid = out_valid_reg;

    a_beat_per_tick: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> m_tvalid)
        else $error("accepted tick produced no result beat");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("tick accepted over an untaken result");

endmodule

[sv/mkdpt_key.sv]
// Debounce state machine and press timer for a single key.
module mkdpt_key (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step,
    input  logic                            level_high,
    input  logic [mkdpt_pkg::SETTLE_W-1:0]  debounce_ticks,
    output mkdpt_pkg::key_stat_t            stat
);
    import mkdpt_pkg::*;

    typedef enum logic [1:0] {
        PH_UP      = 2'd0,
        PH_FALLING = 2'd1,
        PH_DOWN    = 2'd2,
        PH_RISING  = 2'd3
    } phase_t;

    phase_t              phase_reg;
    phase_t              phase_next;
    logic [SETTLE_W-1:0] settle_reg;
    logic [SETTLE_W-1:0] settle_next;
    logic [DUR_W-1:0]    press_reg;
    logic [DUR_W-1:0]    press_next;
    logic [DUR_W-1:0]    last_dur_reg;
    logic [DUR_W-1:0]    last_dur_next;
    logic                release_evt;

    always_comb
    begin
        phase_next    = phase_reg;
        settle_next   = settle_reg;
        press_next    = press_reg;
        last_dur_next = last_dur_reg;
        release_evt   = 1'b0;
        case (phase_reg)
            PH_UP:
            begin
                if (!level_high)
                begin
                    phase_next  = PH_FALLING;
                    settle_next = '0;
                end
            end
            PH_FALLING:
            begin
                if (settle_reg != SETTLE_MAX)
                    settle_next = settle_reg + 1'b1;
                // sample the level again once the wait has run out
                if (settle_next >= debounce_ticks)
                begin
                    if (!level_high)
                    begin
                        phase_next = PH_DOWN;
                        press_next = '0;
                    end
                    else
                        phase_next = PH_UP;
                end
            end
            PH_DOWN:
            begin
                if (press_reg != DUR_MAX)
                    press_next = press_reg + 1'b1;
                if (level_high)
                    phase_next = PH_RISING;
            end
            PH_RISING:
            begin
                if (press_reg != DUR_MAX)
                    press_next = press_reg + 1'b1;
                if (level_high)
                begin
                    last_dur_next = press_next;
                    phase_next    = PH_UP;
                    release_evt   = 1'b1;
                end
                else
                    phase_next = PH_DOWN;
            end
            default:
            begin
                phase_next = PH_UP;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_UP;
            settle_reg   <= '0;
            press_reg    <= '0;
            last_dur_reg <= '0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            settle_reg   <= settle_next;
            press_reg    <= press_next;
            last_dur_reg <= last_dur_next;
        end
    end

    assign stat.release_evt = release_evt;
    assign stat.down        = (phase_next == PH_DOWN) || (phase_next == PH_RISING);
    assign stat.duration    = last_dur_next;

    a_release_from_rising: assert property (@(posedge clk) disable iff (!rst_n)
        release_evt |-> (phase_reg == PH_RISING) && level_high)
        else $error("release without confirmed rise");

    a_release_to_up: assert property (@(posedge clk) disable iff (!rst_n)
        step && release_evt |=> (phase_reg == PH_UP) && (last_dur_reg == $past(press_next)))
        else $error("release did not store duration and return to up");

    a_press_starts_wait: assert property (@(posedge clk) disable iff (!rst_n)
        step && (phase_reg == PH_UP) && !level_high |=>
            (phase_reg == PH_FALLING) && (settle_reg == '0))
        else $error("low level in up did not start debounce wait");

    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(phase_reg) && $stable(press_reg) && $stable(last_dur_reg))
        else $error("key state moved without a tick");

endmodule

[verif/multi_key_debounce_press_timer_top_test.sv]
// Testbench for the multi-key debounce and press timer: tick stream, scoreboard, random keys.
`timescale 1ns / 100ps

module multi_key_debounce_press_timer_top_test;
    import mkdpt_pkg::*;

    typedef enum logic [1:0] {KEY_UP, KEY_FALLING, KEY_DOWN, KEY_RISING} key_phase_e;

    // Matches the m_tdata layout: release_mask lowest, then down_mask, then durations.
    typedef struct packed {
        logic [NUM_KEYS-1:0][DUR_W-1:0] duration;
        logic [NUM_KEYS-1:0]            down_mask;
        logic [NUM_KEYS-1:0]            release_mask;
    } tick_result_t;

    class key_tick_tracker;
        logic [SETTLE_W-1:0] debounce;
        key_phase_e          phase [NUM_KEYS];
        logic [SETTLE_W-1:0] settle [NUM_KEYS];
        logic [DUR_W-1:0]    held [NUM_KEYS];
        logic [DUR_W-1:0]    last_len [NUM_KEYS];
        tick_result_t        tick_results [$];
        int                  errors;
        int                  tick_count;

        function new();
            debounce = DEBOUNCE_RESET;
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                phase[k]    = KEY_UP;
                settle[k]   = '0;
                held[k]     = '0;
                last_len[k] = '0;
            end
            errors     = 0;
            tick_count = 0;
        endfunction

        function void set_debounce(logic [SETTLE_W-1:0] value);
            debounce = value;
        endfunction

        function int pending();
            return tick_results.size();
        endfunction

        // Advance every key machine by one tick and queue the result it yields.
        function void note_tick(logic [NUM_KEYS-1:0] levels);
            tick_result_t r;
            logic         high;
            r = '0;
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                high = levels[k];
                case (phase[k])
                    KEY_UP:
                    begin
                        if (!high)
                        begin
                            phase[k]  = KEY_FALLING;
                            settle[k] = '0;
                        end
                    end
                    KEY_FALLING:
                    begin
                        if (settle[k] != SETTLE_MAX)
                            settle[k] = settle[k] + 1'b1;
                        if (settle[k] >= debounce)
                        begin
                            if (!high)
                            begin
                                phase[k] = KEY_DOWN;
                                held[k]  = '0;
                            end
                            else
                                phase[k] = KEY_UP;
                        end
                    end
                    KEY_DOWN:
                    begin
                        if (held[k] != DUR_MAX)
                            held[k] = held[k] + 1'b1;
                        if (high)
                            phase[k] = KEY_RISING;
                    end
                    default:
                    begin
                        if (held[k] != DUR_MAX)
                            held[k] = held[k] + 1'b1;
                        if (high)
                        begin
                            last_len[k]       = held[k];
                            phase[k]          = KEY_UP;
                            r.release_mask[k] = 1'b1;
                        end
                        else
                            phase[k] = KEY_DOWN;
                    end
                endcase
                r.down_mask[k] = (phase[k] == KEY_DOWN) || (phase[k] == KEY_RISING);
                r.duration[k]  = last_len[k];
            end
            tick_results.push_back(r);
        endfunction

        task report(string what, logic [DUR_W-1:0] exp_val, logic [DUR_W-1:0] got_val);
            if (errors < 40)
                $display("MISMATCH tick %0d %s: expected %0d, got %0d",
                         tick_count, what, exp_val, got_val);
            errors++;
        endtask

        task check_result(logic [OUT_TDATA_W-1:0] beat);
            tick_result_t got;
            tick_result_t exp_r;
            got = beat;
            if (tick_results.size() == 0)
            begin
                report("result with no tick pending", '0, '0);
                return;
            end
            exp_r = tick_results.pop_front();
            if (got.release_mask !== exp_r.release_mask)
                report("release_mask", exp_r.release_mask, got.release_mask);
            if (got.down_mask !== exp_r.down_mask)
                report("down_mask", exp_r.down_mask, got.down_mask);
            for (int k = 0; k < NUM_KEYS; k++)
                if (got.duration[k] !== exp_r.duration[k])
                    report($sformatf("duration key %0d", k), exp_r.duration[k],
                           got.duration[k]);
            tick_count++;
        endtask
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [SETTLE_W-1:0]    cfg_data;

    key_tick_tracker tracker = new();

    int                  burst_left = 0;
    int                  rx_mode = 0;
    logic [6:0]          rx_cycle = '0;
    int                  stall_left = 0;
    logic [NUM_KEYS-1:0] key_level = '1;
    int                  run_left [NUM_KEYS];

    multi_key_debounce_press_timer_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
            tracker.set_debounce(cfg_data);
        if (rst_n && s_tvalid && s_tready)
            tracker.note_tick(s_tdata[NUM_KEYS-1:0]);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_result(m_tdata);
    end

    // Receiver backpressure: the stall mode is picked anew each time the 7-bit rx_cycle counter wraps.
    always @(negedge clk)
    begin
        if (rx_cycle == 0)
            rx_mode = $urandom_range(0, 3);
        rx_cycle = rx_cycle + 1'b1;
        if (stall_left != 0)
        begin
            m_tready   = 1'b0;
            stall_left = stall_left - 1;
        end
        else
        begin
            case (rx_mode)
                0: m_tready = 1'b1;
                1: m_tready = rx_cycle[0];
                2: m_tready = ($urandom_range(0, 3) != 0);
                default:
                begin
                    if ($urandom_range(0, 7) == 0)
                        stall_left = $urandom_range(1, 10);
                    m_tready = 1'b1;
                end
            endcase
        end
    end

    // Called just after a falling edge; leaves s_tvalid high with the beat taken.
    task automatic send_tick(input logic [NUM_KEYS-1:0] levels);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left = burst_left - 1;
        s_tvalid   = 1'b1;
        s_tdata    = {{(IN_TDATA_W-NUM_KEYS){1'b0}}, levels};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // Drop valid and hold until every queued result has come back.
    task automatic drain();
        s_tvalid   = 1'b0;
        burst_left = 0;
        while (tracker.pending() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_debounce(input logic [SETTLE_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Each key toggles after a random run: short runs bounce, long runs make presses.
    task automatic next_levels(input int deb, input logic [NUM_KEYS-1:0] hold_low,
                               output logic [NUM_KEYS-1:0] levels);
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            if (run_left[k] <= 0)
            begin
                key_level[k] = ~key_level[k];
                if ($urandom_range(0, 9) < 3)
                    run_left[k] = $urandom_range(1, 3);
                else
                    run_left[k] = $urandom_range(1, 2 * deb + 8);
            end
            run_left[k] = run_left[k] - 1;
            levels[k] = hold_low[k] ? 1'b0 : key_level[k];
            if (!hold_low[k] && $urandom_range(0, 19) == 0)
                levels[k] = ~levels[k];
        end
    endtask

    task automatic run_keys(input int deb, input int count);
        logic [NUM_KEYS-1:0] levels;
        drain();
        write_debounce(deb[SETTLE_W-1:0]);
        for (int i = 0; i < count; i++)
        begin
            next_levels(deb, '0, levels);
            send_tick(levels);
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        for (int k = 0; k < NUM_KEYS; k++)
            run_left[k] = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // At the reset debounce, start every key falling, then shorten the wait
        // so the count already past it samples at once.
        send_tick(4'hF);
        send_tick(4'h0);
        send_tick(4'hA);
        drain();
        write_debounce(8'd1);
        send_tick(4'h5);
        send_tick(4'h0);
        send_tick(4'h0);
        send_tick(4'hF);
        send_tick(4'h0);
        send_tick(4'hF);
        send_tick(4'hF);
        // glitch on key 0, clean press on key 3
        send_tick(4'hE);
        send_tick(4'hF);
        send_tick(4'h7);
        send_tick(4'h7);
        send_tick(4'hF);
        send_tick(4'hF);
        drain();
        write_debounce(8'd0);
        send_tick(4'h0);
        send_tick(4'h0);
        send_tick(4'h0);
        send_tick(4'hF);
        send_tick(4'hF);

        run_keys(1, 60);
        run_keys(255, 150);
        run_keys(0, 40);
        run_keys(int'(DEBOUNCE_RESET), 80);
        run_keys($urandom_range(2, 40), 60);
        run_keys($urandom_range(1, 255), 60);
        run_keys($urandom_range(1, 12), 30);

        drain();
        repeat (5) @(negedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

[filelist.f]
sv/mkdpt_pkg.sv
sv/mkdpt_key.sv
sv/multi_key_debounce_press_timer_top.sv
verif/multi_key_debounce_press_timer_top_test.sv
